// ===== src/wmad_pkg.sv =====
`timescale 1ns / 1ps

package wmad_pkg;

    localparam int LEVEL_W        = 16;
    localparam int MS_W           = 16;
    localparam int EVENT_W        = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int DEF_WINDOW     = 120;
    localparam int THRESHOLD_RST  = 15360;
    localparam int HOLDOFF_RST    = 5000;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        ALERT_NONE     = 2'd0,
        ALERT_LOW      = 2'd1,
        ALERT_RECOVERY = 2'd2
    } t_alert;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUB,
        S_ADD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== src/wmad_in_if.sv =====
`timescale 1ns / 1ps

interface wmad_in_if
    import wmad_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [LEVEL_W-1:0] level_sample;

    modport source (output valid, output opcode, output level_sample, input ready);
    modport sink   (input valid, input opcode, input level_sample, output ready);
endinterface

// ===== src/wmad_out_if.sv =====
`timescale 1ns / 1ps

interface wmad_out_if
    import wmad_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] window_mean;
    logic               above_threshold;
    logic [EVENT_W-1:0] alert_event;

    modport source (
        output valid, output window_mean, output above_threshold, output alert_event,
        input ready
    );
    modport sink (
        input valid, input window_mean, input above_threshold, input alert_event,
        output ready
    );
endinterface

// ===== src/wmad_ring.sv =====
`timescale 1ns / 1ps

module wmad_ring
    import wmad_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW,
    parameter int SLOT_W = $clog2(WINDOW)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [SLOT_W-1:0]  i_waddr,
    input  logic [LEVEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [SLOT_W-1:0]  i_raddr,
    output logic [LEVEL_W-1:0] o_rdata
);

    logic [LEVEL_W-1:0] r_mem [WINDOW];
    logic [LEVEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/windowed_mean_alert_detector_core.sv =====
`timescale 1ns / 1ps

// Windowed mean level detector with alert holdoff.
// The input channel carries sample transfers (opcode 0, Q8.8 level) and
// millisecond tick transfers (opcode 1). Each sample yields one result
// transfer on the output channel: the floor mean of the last WINDOW
// samples (of all samples until the window is full), a flag for a mean
// above the threshold, and an alert code. Ticks yield no result and
// leave the block idle. A sample passes through the read, subtract, add,
// divide and done states before its result is loaded. The restoring
// divider retires one quotient bit a cycle on the shared adder.
// The block takes one item at a time and is ready only when idle, so the
// next item is taken only after the result of a sample has been loaded.
// The configuration port writes the threshold and the holdoff, and is to
// be used only while the block is idle; the block itself does not enforce it.
// Reset empties the window, clears the millisecond counter and alert state
// and restores the register defaults. If the receiver stalls, the result
// waits in the output register and the block holds before loading the
// next result until that register is free.
module windowed_mean_alert_detector_core
    import wmad_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wmad_in_if.sink              i_item,
    wmad_out_if.source           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ((1 << LEVEL_W) - 1) + 1);
    localparam int U_W    = SUM_W + 1;
    localparam int DCNT_W = $clog2(SUM_W);

    t_state r_state, n_state;

    logic [LEVEL_W-1:0] r_thr;
    logic [MS_W-1:0]    r_holdoff;
    logic [MS_W-1:0]    r_elapsed;
    logic               r_low_raised;
    logic [CNT_W-1:0]   r_fill;
    logic [SLOT_W-1:0]  r_slot;
    logic [SUM_W-1:0]   r_sum;
    logic [LEVEL_W-1:0] r_sample;
    logic [SUM_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_rem;
    logic [DCNT_W-1:0]  r_dcnt;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_mean;
    logic               r_out_high;
    t_alert             r_out_event;

    logic [LEVEL_W-1:0] old_sample;
    logic               ring_we;
    logic               ring_re;
    logic               full;
    logic               in_xfer;
    logic               out_load;

    logic [U_W-1:0]     unit_a;
    logic [U_W-1:0]     unit_b;
    logic               unit_sub;
    logic [U_W:0]       unit_full;
    logic [U_W-1:0]     unit_res;
    logic               unit_carry;

    logic [CNT_W:0]     trial;
    logic [LEVEL_W-1:0] mean;
    logic               high;
    logic               time_ok;
    t_alert             alert;

    wmad_ring #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (ring_re),
        .i_raddr (r_slot),
        .o_rdata (old_sample)
    );

    assign full    = (r_fill == CNT_W'(WINDOW));
    assign in_xfer = i_item.valid && i_item.ready;
    assign trial   = {r_rem, r_quo[SUM_W-1]};
    assign mean    = r_quo[LEVEL_W-1:0];
    assign high    = (mean > r_thr);
    assign time_ok = (r_elapsed > r_holdoff);

    // Shared adder and subtractor; carry high on a subtraction means no borrow.
    assign unit_full  = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                        + (U_W + 1)'(unit_sub);
    assign unit_res   = unit_full[U_W-1:0];
    assign unit_carry = unit_full[U_W];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && i_item.opcode == OP_SAMPLE) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_SUB;
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == DCNT_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = (r_state == S_IDLE);
        ring_re      = (r_state == S_READ);
        ring_we      = (r_state == S_SUB);
        out_load     = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
        unit_a       = U_W'(r_sum);
        unit_b       = '0;
        unit_sub     = 1'b0;
        alert        = ALERT_NONE;
        unique case (r_state)
            S_SUB: begin
                unit_b   = U_W'(old_sample);
                unit_sub = 1'b1;
            end
            S_ADD: begin
                unit_b = U_W'(r_sample);
            end
            S_DIV: begin
                unit_a   = U_W'(trial);
                unit_b   = U_W'(r_fill);
                unit_sub = 1'b1;
            end
            S_DONE: begin
                if (time_ok && high && r_low_raised) begin
                    alert = ALERT_RECOVERY;
                end else if (time_ok && !high && !r_low_raised) begin
                    alert = ALERT_LOW;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= LEVEL_W'(THRESHOLD_RST);
            r_holdoff <= MS_W'(HOLDOFF_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr     <= i_cfg_data;
                CFG_HOLDOFF:   r_holdoff <= MS_W'(i_cfg_data);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed    <= '0;
            r_low_raised <= 1'b0;
            r_fill       <= '0;
            r_slot       <= '0;
            r_sum        <= '0;
        end else begin
            if (in_xfer && i_item.opcode == OP_TICK && r_elapsed != '1) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (r_state == S_SUB) begin
                if (full) begin
                    r_sum <= unit_res[SUM_W-1:0];
                end else begin
                    r_fill <= r_fill + 1'b1;
                end
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
            if (r_state == S_ADD) begin
                r_sum <= unit_res[SUM_W-1:0];
            end
            if (out_load && alert != ALERT_NONE) begin
                r_elapsed    <= '0;
                r_low_raised <= (alert == ALERT_LOW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_item.level_sample;
        end
        if (r_state == S_ADD) begin
            r_quo  <= unit_res[SUM_W-1:0];
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (r_state == S_DIV) begin
            r_quo  <= {r_quo[SUM_W-2:0], unit_carry};
            r_rem  <= unit_carry ? unit_res[CNT_W-1:0] : trial[CNT_W-1:0];
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mean  <= mean;
            r_out_high  <= high;
            r_out_event <= alert;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.window_mean     = r_out_mean;
    assign o_result.above_threshold = r_out_high;
    assign o_result.alert_event     = r_out_event;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(WINDOW))
        else $error("write slot beyond window");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_item.opcode == OP_SAMPLE |=> r_state == S_READ)
        else $error("sample transfer did not start the sequence");

    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && alert != ALERT_NONE |=> r_elapsed == '0)
        else $error("alert did not clear the millisecond counter");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wmad_pkg::*;

    localparam int WIN       = DEF_WINDOW;
    localparam int SETTLE    = 40;
    localparam int MAX_SHOWN = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0] mean;
        logic               above;
        t_alert             alert;
    } t_mean_result;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;

    wmad_in_if  item_if ();
    wmad_out_if result_if ();

    windowed_mean_alert_detector_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor state, mirroring the block.
    logic [LEVEL_W-1:0] ring [WIN];
    int                 fill_count;
    int                 write_slot;
    int unsigned        window_sum;
    int                 elapsed_ms;
    logic               low_raised;
    logic [LEVEL_W-1:0] level_threshold;
    logic [LEVEL_W-1:0] holdoff_ms;

    t_mean_result pending_results [$];
    int           mismatches;
    bit           sender_idles;
    bit           receiver_idles;
    int           receiver_hold;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_mean_result predict_sample(input logic [LEVEL_W-1:0] lvl);
        t_mean_result r;
        if (fill_count >= WIN) begin
            window_sum -= ring[write_slot];
        end else begin
            fill_count++;
        end
        ring[write_slot] = lvl;
        window_sum += lvl;
        write_slot = (write_slot + 1) % WIN;
        r.mean = LEVEL_W'(window_sum / fill_count);
        r.above = (r.mean > level_threshold);
        r.alert = ALERT_NONE;
        if (elapsed_ms > holdoff_ms) begin
            if (r.above && low_raised) begin
                r.alert = ALERT_RECOVERY;
                low_raised = 1'b0;
                elapsed_ms = 0;
            end else if (!r.above && !low_raised) begin
                r.alert = ALERT_LOW;
                low_raised = 1'b1;
                elapsed_ms = 0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t: %s mismatch, wanted %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_mean_result want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 0, result_if.window_mean);
            end else begin
                want = pending_results.pop_front();
                if (result_if.window_mean !== want.mean)
                    report_mismatch("window_mean", want.mean, result_if.window_mean);
                if (result_if.above_threshold !== want.above)
                    report_mismatch("above_threshold", want.above, result_if.above_threshold);
                if (result_if.alert_event !== want.alert)
                    report_mismatch("alert_event", want.alert, result_if.alert_event);
            end
        end
    end

    // Result receiver: random stalls, plus an occasional long hold requested by a test.
    initial begin : receiver
        int n;
        result_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            n = receiver_idles ? $urandom_range(5, 0) : 0;
            if (receiver_hold > 0) begin
                n = receiver_hold;
                receiver_hold = 0;
            end
            if (n > 0) begin
                result_if.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!(result_if.valid && result_if.ready));
            @(negedge clk);
        end
    end

    // Called at a falling edge; returns at a falling edge with the item still offered,
    // so that a following item can be presented without a gap.
    task automatic send_item(input logic op, input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = sender_idles ? $urandom_range(5, 0) : 0;
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.opcode       <= op;
        item_if.level_sample <= lvl;
        do @(posedge clk); while (!item_if.ready);
        if (op == OP_TICK) begin
            if (elapsed_ms < 65535) elapsed_ms++;
        end else begin
            pending_results = {pending_results, predict_sample(lvl)};
        end
        @(negedge clk);
    endtask

    task automatic wait_drain();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Writes both registers on consecutive cycles; the block must be idle.
    task automatic set_config(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] hold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_index <= CFG_HOLDOFF;
        cfg_data  <= hold;
        @(negedge clk);
        cfg_we <= 1'b0;
        level_threshold = thr;
        holdoff_ms = hold;
    endtask

    task automatic test_directed();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h3C01);
        wait_drain();
        set_config(16'hFFFF, 16'd0);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'hAAAA);
        wait_drain();
        set_config(16'd0, 16'd0);
        send_item(OP_TICK, 16'h5555);
        send_item(OP_SAMPLE, 16'h0001);
        send_item(OP_TICK, 16'hAAAA);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_SAMPLE, 16'h5555);
        wait_drain();
        set_config(16'h8000, 16'd2);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        wait_drain();
    endtask

    // Fills the window with the largest level so that the oldest sample is
    // dropped repeatedly and the sum reaches its maximum.
    task automatic test_full_window();
        set_config(16'hFFFE, 16'd0);
        for (int i = 0; i < WIN + 10; i++) send_item(OP_SAMPLE, 16'hFFFF);
        for (int i = 0; i < 10; i++) send_item(OP_SAMPLE, 16'h0000);
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_config(16'h4000, 16'd1);
        receiver_hold = 300;
        sender_idles = 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_item(OP_TICK, 16'h0000);
            send_item(OP_SAMPLE, LEVEL_W'($urandom));
        end
        wait_drain();
        sender_idles = 1'b1;
    endtask

    task automatic test_random();
        logic [LEVEL_W-1:0] thr;
        logic [LEVEL_W-1:0] hold;
        logic [LEVEL_W-1:0] lvl;
        bit                 high_band;
        int                 run_left;
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(5, 0))
                0: thr = 16'h0000;
                1: thr = 16'hFFFF;
                2: thr = LEVEL_W'($urandom);
                default: thr = LEVEL_W'($urandom_range(16'hC000, 16'h4000));
            endcase
            case ($urandom_range(7, 0))
                0: hold = 16'd0;
                1: hold = 16'hFFFF;
                2, 3: hold = LEVEL_W'($urandom_range(30, 7));
                default: hold = LEVEL_W'($urandom_range(6, 1));
            endcase
            set_config(thr, hold);
            sender_idles = (phase % 3) != 2;
            receiver_idles = (phase % 4) != 1;
            run_left = 0;
            high_band = 1'b0;
            for (int i = 0; i < 78; i++) begin
                if (run_left == 0) begin
                    high_band = ~high_band;
                    run_left = $urandom_range(40, 5);
                end
                if ($urandom_range(99, 0) < 35) begin
                    send_item(OP_TICK, LEVEL_W'($urandom));
                end else begin
                    run_left--;
                    if ($urandom_range(9, 0) == 0) lvl = LEVEL_W'($urandom);
                    else if (high_band) lvl = LEVEL_W'($urandom_range(16'hFFFF, 16'hA000));
                    else lvl = LEVEL_W'($urandom_range(16'h5FFF, 16'h0000));
                    send_item(OP_SAMPLE, lvl);
                end
            end
            wait_drain();
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.opcode = OP_SAMPLE;
        item_if.level_sample = '0;
        mismatches = 0;
        receiver_hold = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        fill_count = 0;
        write_slot = 0;
        window_sum = 0;
        elapsed_ms = 0;
        low_raised = 1'b0;
        level_threshold = LEVEL_W'(THRESHOLD_RST);
        holdoff_ms = LEVEL_W'(HOLDOFF_RST);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_window();
        test_backpressure();
        test_random();

        wait_drain();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/wmad_pkg.sv
src/wmad_in_if.sv
src/wmad_out_if.sv
src/wmad_ring.sv
src/windowed_mean_alert_detector_core.sv
verif/testbench.sv
